FILE: rtl/core/abts_pkg.sv
// Package for the array binary tree store.
// Holds field widths, operation and status codes, and reset constants.
// No dependencies.
package abts_pkg;

    localparam int NODE_COUNT_DEF = 127;

    localparam int OP_W    = 3;
    localparam int LAYER_W = 3;
    localparam int ORDER_W = 7;
    localparam int VAL_W   = 8;
    localparam int STAT_W  = 2;
    localparam int DEPTH_W = 3;
    localparam int POS_W   = 7;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [VAL_W-1:0]   EMPTY_RESET = 8'd32;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 3'd7;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_PARENT = 3'd3;
    localparam logic [OP_W-1:0] OP_LCHILD = 3'd4;
    localparam logic [OP_W-1:0] OP_RCHILD = 3'd5;
    localparam logic [OP_W-1:0] OP_LSIB   = 3'd6;
    localparam logic [OP_W-1:0] OP_RSIB   = 3'd7;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOKEY   = 2'd3;

endpackage

FILE: rtl/core/abts_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Used for the node store of the array binary tree store. No dependencies.
module abts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 127
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/array_binary_tree_store.sv
// Array binary tree store: level-order byte tree kept in one RAM.
// Throughput: one item at a time; every item but a clear runs a scan of the store, one node
// per cycle through the single RAM read port, to find the key and the tree depth.
// Reset: a sweep writes the empty code 32 into every node; no item is accepted during the
// sweep, while configuration writes are taken.
// Depends on abts_pkg and abts_ram.
module array_binary_tree_store #(
    parameter int NODE_COUNT = abts_pkg::NODE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // op [2:0], layer [5:3], order [12:6], node_value [20:13], zero fill above.
    input  logic [abts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // result_value [7:0], status [9:8], tree_depth [12:10], zero fill above.
    output logic [abts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [abts_pkg::VAL_W-1:0]      cfg_data
);

    import abts_pkg::*;

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CNT_W = $clog2(NODE_COUNT + 1);
    localparam int EXT_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;
    localparam logic [EXT_W-1:0] NODES    = EXT_W'(NODE_COUNT);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NODE_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NODE_COUNT);

    localparam logic [3:0] ST_INIT = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_CLR  = 4'd2;
    localparam logic [3:0] ST_PRE  = 4'd3;
    localparam logic [3:0] ST_EVAL = 4'd4;
    localparam logic [3:0] ST_SCAN = 4'd5;
    localparam logic [3:0] ST_REL  = 4'd6;
    localparam logic [3:0] ST_RELW = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    function automatic logic [DEPTH_W-1:0] depth_of(input logic [CNT_W-1:0] cnt);
        int d;
        d = 0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (cnt[i])
            begin
                d = i + 1;
            end
        end
        if (d > 7)
        begin
            d = 7;
        end
        return DEPTH_W'(d);
    endfunction

    logic [3:0]         state_reg, state_next;
    logic [VAL_W-1:0]   empty_code_reg;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [VAL_W-1:0]   key_reg, key_next;
    logic [EXT_W-1:0]   idx_reg, idx_next;
    logic               range_reg, range_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]   last_nz_reg, last_nz_next;
    logic               found_reg, found_next;
    logic [CNT_W-1:0]   match_reg, match_next;
    logic [VAL_W-1:0]   root_reg, root_next;
    logic [2:0]         seq_reg, seq_next;
    logic               oob_reg, oob_next;
    logic [VAL_W-1:0]   val_reg [4];
    logic [VAL_W-1:0]   val_next [4];
    logic [VAL_W-1:0]   res_reg, res_next;
    logic [STAT_W-1:0]  st_reg, st_next;
    logic               out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]   out_res_reg, out_res_next;
    logic [STAT_W-1:0]  out_st_reg, out_st_next;
    logic [DEPTH_W-1:0] out_depth_reg, out_depth_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [VAL_W-1:0]   ram_wdata, ram_rdata;

    logic [OP_W-1:0]    in_op;
    logic [LAYER_W-1:0] in_layer;
    logic [ORDER_W-1:0] in_order;
    logic [VAL_W-1:0]   in_value;
    logic [POS_W-1:0]   row_len, pos_idx;
    logic               pos_ok, in_range;
    logic [EXT_W-1:0]   pos_ext, parent_ext, c1_ext, c2_ext, slot_ext, m_ext, rel_ext;
    logic               in_accept, refuse, key_hit;

    abts_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NODE_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_op    = s_axis_tdata[2:0];
    assign in_layer = s_axis_tdata[5:3];
    assign in_order = s_axis_tdata[12:6];
    assign in_value = s_axis_tdata[20:13];

    assign row_len  = (in_layer == '0) ? '0 : (POS_W'(1) << (in_layer - 3'd1));
    assign pos_ok   = (in_layer != '0) && (in_order != '0) && (in_order <= row_len);
    assign pos_idx  = row_len - POS_W'(1) + (in_order - ORDER_W'(1));
    assign pos_ext  = EXT_W'(pos_idx);
    assign in_range = pos_ok && (pos_ext < NODES);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_depth_reg, out_st_reg, out_res_reg};

    assign parent_ext = (idx_reg == '0) ? '0 : ((idx_reg - EXT_W'(1)) >> 1);
    assign c1_ext     = (idx_reg << 1) + EXT_W'(1);
    assign c2_ext     = (idx_reg << 1) + EXT_W'(2);

    assign m_ext = EXT_W'(match_reg);

    always_comb
    begin
        case (seq_reg[1:0])
            2'd0:    slot_ext = idx_reg;
            2'd1:    slot_ext = parent_ext;
            2'd2:    slot_ext = c1_ext;
            default: slot_ext = c2_ext;
        endcase
    end

    always_comb
    begin
        case (op_reg)
            OP_PARENT: rel_ext = (m_ext - EXT_W'(1)) >> 1;
            OP_LCHILD: rel_ext = (m_ext << 1) + EXT_W'(1);
            OP_RCHILD: rel_ext = (m_ext << 1) + EXT_W'(2);
            OP_LSIB:   rel_ext = m_ext - EXT_W'(1);
            default:   rel_ext = m_ext + EXT_W'(1);
        endcase
    end

    assign refuse = ((key_reg != empty_code_reg) && (idx_reg != '0)
                     && (val_reg[1] == empty_code_reg))
                 || ((key_reg == empty_code_reg)
                     && ((val_reg[2] != empty_code_reg) || (val_reg[3] != empty_code_reg)));

    always_comb
    begin
        key_hit = (key_reg != empty_code_reg) && (ram_rdata == key_reg) && !found_reg;
        case (op_reg)
            OP_PARENT: key_hit = key_hit && (pend_idx_reg != '0);
            OP_LSIB:   key_hit = key_hit && (pend_idx_reg != '0) && !pend_idx_reg[0];
            OP_RSIB:   key_hit = key_hit && pend_idx_reg[0];
            default:   key_hit = key_hit;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        range_next     = range_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        last_nz_next   = last_nz_reg;
        found_next     = found_reg;
        match_next     = match_reg;
        root_next      = root_reg;
        seq_next       = seq_reg;
        oob_next       = oob_reg;
        val_next       = val_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_st_next    = out_st_reg;
        out_depth_next = out_depth_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[IDX_W-1:0];
        ram_wdata      = empty_code_reg;
        ram_raddr      = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = EMPTY_RESET;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next      = in_op;
                    key_next     = in_value;
                    idx_next     = pos_ext;
                    range_next   = in_range;
                    cnt_next     = '0;
                    seq_next     = '0;
                    pend_next    = 1'b0;
                    last_nz_next = '0;
                    found_next   = 1'b0;
                    res_next     = empty_code_reg;
                    st_next      = STAT_OK;
                    case (in_op)
                        OP_CLEAR: state_next = ST_CLR;
                        OP_WRITE,
                        OP_READ:  state_next = in_range ? ST_PRE : ST_EVAL;
                        default:  state_next = ST_SCAN;
                    endcase
                end
            end
            ST_CLR:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    last_nz_next = '0;
                    state_next   = ST_DONE;
                end
            end
            ST_PRE:
            begin
                if (seq_reg != 3'd4)
                begin
                    ram_raddr = (slot_ext < NODES) ? slot_ext[IDX_W-1:0] : '0;
                    oob_next  = !(slot_ext < NODES);
                end
                if (seq_reg != 3'd0)
                begin
                    val_next[2'(seq_reg - 3'd1)] = oob_reg ? empty_code_reg : ram_rdata;
                end
                seq_next = seq_reg + 3'd1;
                if (seq_reg == 3'd4)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!range_reg)
                begin
                    res_next = empty_code_reg;
                    st_next  = STAT_RANGE;
                end
                else if (op_reg == OP_READ)
                begin
                    res_next = val_reg[0];
                    st_next  = STAT_OK;
                end
                else if (refuse)
                begin
                    res_next = val_reg[0];
                    st_next  = STAT_REFUSED;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg[IDX_W-1:0];
                    ram_wdata = key_reg;
                    res_next  = key_reg;
                    st_next   = STAT_OK;
                end
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cnt_reg != CNT_END)
                begin
                    ram_raddr     = cnt_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = cnt_reg;
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (ram_rdata != empty_code_reg)
                    begin
                        last_nz_next = pend_idx_reg + CNT_W'(1);
                    end
                    if (pend_idx_reg == '0)
                    begin
                        root_next = ram_rdata;
                    end
                    if (key_hit)
                    begin
                        found_next = 1'b1;
                        match_next = pend_idx_reg;
                    end
                end
                if ((cnt_reg == CNT_END) && !pend_reg)
                begin
                    if ((op_reg == OP_WRITE) || (op_reg == OP_READ))
                    begin
                        state_next = ST_DONE;
                    end
                    else if ((root_reg == empty_code_reg) || !found_reg)
                    begin
                        res_next   = empty_code_reg;
                        st_next    = STAT_NOKEY;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_REL;
                    end
                end
            end
            ST_REL:
            begin
                st_next = STAT_OK;
                if (rel_ext < NODES)
                begin
                    ram_raddr  = rel_ext[IDX_W-1:0];
                    state_next = ST_RELW;
                end
                else
                begin
                    res_next   = empty_code_reg;
                    state_next = ST_DONE;
                end
            end
            ST_RELW:
            begin
                res_next   = ram_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_st_next    = st_reg;
                    out_depth_next = depth_of(last_nz_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            empty_code_reg <= EMPTY_RESET;
            op_reg         <= OP_CLEAR;
            key_reg        <= '0;
            idx_reg        <= '0;
            range_reg      <= 1'b0;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            last_nz_reg    <= '0;
            found_reg      <= 1'b0;
            match_reg      <= '0;
            root_reg       <= '0;
            seq_reg        <= '0;
            oob_reg        <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                val_reg[i] <= '0;
            end
            res_reg        <= '0;
            st_reg         <= STAT_OK;
            out_valid_reg  <= 1'b0;
            out_res_reg    <= '0;
            out_st_reg     <= STAT_OK;
            out_depth_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                empty_code_reg <= cfg_data;
            end
            op_reg         <= op_next;
            key_reg        <= key_next;
            idx_reg        <= idx_next;
            range_reg      <= range_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            pend_idx_reg   <= pend_idx_next;
            last_nz_reg    <= last_nz_next;
            found_reg      <= found_next;
            match_reg      <= match_next;
            root_reg       <= root_next;
            seq_reg        <= seq_next;
            oob_reg        <= oob_next;
            val_reg        <= val_next;
            res_reg        <= res_next;
            st_reg         <= st_next;
            out_valid_reg  <= out_valid_next;
            out_res_reg    <= out_res_next;
            out_st_reg     <= out_st_next;
            out_depth_reg  <= out_depth_next;
        end
    end

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (EXT_W'(ram_waddr) < NODES))
        else $error("Node store written beyond its depth.");

    a_scan_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !ram_we)
        else $error("Node store written during a scan.");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("Result raised outside the completion step.");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != ST_IDLE))
        else $error("Accepted transaction did not start processing.");

endmodule

FILE: test/abts_checker.sv
// Checker for the array binary tree store: watches the input, result and configuration channels,
// predicts each result from its own copy of the node store, and counts mismatches.
// Depends on abts_pkg.
`timescale 1ns / 100ps
module abts_checker #(
    parameter int NODES = abts_pkg::NODE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [abts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [abts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [abts_pkg::VAL_W-1:0]      cfg_data,
    output int                              mismatches,
    output int                              awaiting,
    output int                              replies_checked
);
    import abts_pkg::*;

    // Member order follows the result bus, highest field first.
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [STAT_W-1:0]  status;
        logic [VAL_W-1:0]   value;
    } tree_reply_t;

    logic [VAL_W-1:0] shadow_nodes [NODES];
    logic [VAL_W-1:0] blank_code;
    tree_reply_t      reply_queue [$];

    function automatic logic [VAL_W-1:0] node_at(input int unsigned idx);
        return (idx < NODES) ? shadow_nodes[idx] : blank_code;
    endfunction

    // Returns NODES when no node from start on holds the key with the wanted index parity.
    function automatic int unsigned first_holder(input logic [VAL_W-1:0] key,
                                                 input int unsigned start, input int parity);
        int unsigned i;
        if (key == blank_code)
            return NODES;
        for (i = start; i < NODES; i++)
        begin
            if (shadow_nodes[i] == key && (parity == 2 || int'(i & 1) == parity))
                return i;
        end
        return NODES;
    endfunction

    function automatic logic [DEPTH_W-1:0] depth_now();
        int unsigned last;
        int unsigned bits;
        last = 0;
        bits = 0;
        for (int unsigned i = 0; i < NODES; i++)
        begin
            if (shadow_nodes[i] != blank_code)
                last = i + 1;
        end
        while (last != 0)
        begin
            bits++;
            last >>= 1;
        end
        return (bits > 7) ? DEPTH_MAX : bits[DEPTH_W-1:0];
    endfunction

    task automatic apply_op(input logic [IN_DATA_W-1:0] word, output tree_reply_t reply);
        logic [OP_W-1:0]   op;
        int unsigned       layer;
        int unsigned       order;
        logic [VAL_W-1:0]  key;
        logic [VAL_W-1:0]  found;
        logic [STAT_W-1:0] st;
        int unsigned       idx;
        int unsigned       hit;
        bit                in_range;
        op       = word[2:0];
        layer    = 32'(word[5:3]);
        order    = 32'(word[12:6]);
        key      = word[20:13];
        idx      = 0;
        in_range = 1'b0;
        found    = blank_code;
        st       = STAT_OK;
        if (layer >= 1 && order >= 1 && order <= (1 << (layer - 1)))
        begin
            idx      = (1 << (layer - 1)) - 1 + (order - 1);
            in_range = idx < NODES;
        end
        case (op)
            OP_CLEAR:
            begin
                for (int unsigned i = 0; i < NODES; i++)
                    shadow_nodes[i] = blank_code;
            end
            OP_WRITE:
            begin
                if (!in_range)
                    st = STAT_RANGE;
                else if (key != blank_code && idx != 0 &&
                         shadow_nodes[(idx - 1) / 2] == blank_code)
                begin
                    st    = STAT_REFUSED;
                    found = shadow_nodes[idx];
                end
                else if (key == blank_code && (node_at(2 * idx + 1) != blank_code ||
                                               node_at(2 * idx + 2) != blank_code))
                begin
                    st    = STAT_REFUSED;
                    found = shadow_nodes[idx];
                end
                else
                begin
                    shadow_nodes[idx] = key;
                    found             = key;
                end
            end
            OP_READ:
            begin
                if (!in_range)
                    st = STAT_RANGE;
                else
                    found = shadow_nodes[idx];
            end
            default:
            begin
                if (shadow_nodes[0] == blank_code)
                    st = STAT_NOKEY;
                else
                begin
                    case (op)
                        OP_PARENT:           hit = first_holder(key, 1, 2);
                        OP_LCHILD, OP_RCHILD: hit = first_holder(key, 0, 2);
                        OP_LSIB:             hit = first_holder(key, 1, 0);
                        default:             hit = first_holder(key, 1, 1);
                    endcase
                    if (hit >= NODES)
                        st = STAT_NOKEY;
                    else
                    begin
                        case (op)
                            OP_PARENT: found = shadow_nodes[(hit - 1) / 2];
                            OP_LCHILD: found = node_at(2 * hit + 1);
                            OP_RCHILD: found = node_at(2 * hit + 2);
                            OP_LSIB:   found = shadow_nodes[hit - 1];
                            default:   found = node_at(hit + 1);
                        endcase
                    end
                end
            end
        endcase
        reply.value  = found;
        reply.status = st;
        reply.depth  = depth_now();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tree_reply_t want;
        tree_reply_t got;
        if (!rst_n)
        begin
            for (int unsigned i = 0; i < NODES; i++)
                shadow_nodes[i] = EMPTY_RESET;
            blank_code = EMPTY_RESET;
            reply_queue.delete();
            mismatches      = 0;
            awaiting        = 0;
            replies_checked = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[12:0];
                if (reply_queue.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result transaction with nothing expected, actual %h",
                             $time, got);
                end
                else
                begin
                    want = reply_queue.pop_front();
                    replies_checked++;
                    if (got.value !== want.value)
                    begin
                        mismatches++;
                        $display("%0t: result_value expected %0d, actual %0d",
                                 $time, want.value, got.value);
                    end
                    if (got.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.depth !== want.depth)
                    begin
                        mismatches++;
                        $display("%0t: tree_depth expected %0d, actual %0d",
                                 $time, want.depth, got.depth);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                blank_code = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_op(s_axis_tdata, want);
                reply_queue.push_back(want);
            end
            awaiting = reply_queue.size();
        end
    end

endmodule

FILE: test/tb.sv
// Top of the array binary tree store testbench: clock, reset, stimulus and verdict.
// Results are predicted and compared by abts_checker; depends on abts_pkg and the block.
`timescale 1ns / 100ps
module tb;
    import abts_pkg::*;

    localparam int CYCLE_LIMIT = 1_200_000;
    localparam int HOLD_CYCLES = 1000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [VAL_W-1:0]      cfg_data;

    int               mismatches;
    int               pending;
    int               replies_checked;
    int               cycles;
    int               items_sent;
    int               op_tally [8];
    bit               calm;
    bit               sink_hold;
    logic [VAL_W-1:0] cur_blank;
    logic [VAL_W-1:0] key_pool [6];

    array_binary_tree_store i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    abts_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .awaiting        (pending),
        .replies_checked (replies_checked)
    );

    initial
        clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stalls in some stretches, and one long hold-off on request.
    initial
    begin
        int  rx_ticks;
        bit  lazy_stretch;
        rx_ticks      = 0;
        lazy_stretch  = 1'b1;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_ticks++;
            if (rx_ticks % 512 == 0)
                lazy_stretch = ($urandom_range(0, 2) != 0);
            if (sink_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                sink_hold = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!calm && lazy_stretch && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at a falling edge after the transaction.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [LAYER_W-1:0] layer,
                             input logic [ORDER_W-1:0] order, input logic [VAL_W-1:0] value);
        s_axis_tdata  <= {3'b000, value, order, layer, op};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        op_tally[op]++;
        items_sent++;
        @(negedge clk);
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_blank(input logic [VAL_W-1:0] code);
        drain();
        cfg_data  <= code;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_blank = code;
    endtask

    function automatic logic [VAL_W-1:0] pick_key();
        if ($urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, 5)];
        return VAL_W'($urandom_range(0, 255));
    endfunction

    // Writes a chain of nodes, keyed from the key pool, from the root down a random path.
    task automatic grow_branch();
        int          reach;
        int unsigned pos;
        reach = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
        pos   = 1;
        for (int lvl = 1; lvl <= reach; lvl++)
        begin
            send_item(OP_WRITE, LAYER_W'(lvl), ORDER_W'(pos), key_pool[$urandom_range(0, 5)]);
            pos = 2 * pos - $urandom_range(0, 1);
        end
    endtask

    // Empties a random path from its deepest node upward.
    task automatic prune_branch();
        int          reach;
        int          stop;
        int unsigned path [8];
        reach   = $urandom_range(2, 7);
        stop    = $urandom_range(1, reach);
        path[1] = 1;
        for (int lvl = 2; lvl <= reach; lvl++)
            path[lvl] = 2 * path[lvl - 1] - $urandom_range(0, 1);
        for (int lvl = reach; lvl >= stop; lvl--)
            send_item(OP_WRITE, LAYER_W'(lvl), ORDER_W'(path[lvl]), cur_blank);
    endtask

    task automatic run_mix(input int count);
        int stop_at;
        int pick;
        int layer;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                send_item(OP_CLEAR, LAYER_W'($urandom_range(0, 7)),
                          ORDER_W'($urandom_range(0, 127)), VAL_W'($urandom_range(0, 255)));
            else if (pick < 37)
                grow_branch();
            else if (pick < 47)
                prune_branch();
            else if (pick < 85)
            begin
                layer = $urandom_range(1, 7);
                send_item(OP_W'($urandom_range(OP_READ, OP_RSIB)), LAYER_W'(layer),
                          ORDER_W'($urandom_range(1, 1 << (layer - 1))), pick_key());
            end
            else
                send_item(OP_W'($urandom_range(OP_WRITE, OP_RSIB)),
                          LAYER_W'($urandom_range(0, 7)), ORDER_W'($urandom_range(0, 127)),
                          VAL_W'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        logic [VAL_W-1:0] phase_codes [5];
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        calm          = 1'b0;
        sink_hold     = 1'b0;
        cycles        = 0;
        items_sent    = 0;
        cur_blank     = EMPTY_RESET;
        foreach (op_tally[i])
            op_tally[i] = 0;
        phase_codes[0] = 8'd0;
        phase_codes[1] = 8'd255;
        phase_codes[2] = VAL_W'($urandom_range(1, 254));
        phase_codes[3] = EMPTY_RESET;
        phase_codes[4] = VAL_W'($urandom_range(0, 255));
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        send_item(OP_READ, 1, 1, 0);
        send_item(OP_PARENT, 1, 1, 10);
        send_item(OP_WRITE, 2, 1, 5);
        send_item(OP_WRITE, 1, 1, 10);
        send_item(OP_WRITE, 2, 1, 20);
        send_item(OP_WRITE, 2, 2, 30);
        send_item(OP_WRITE, 3, 1, 40);
        send_item(OP_WRITE, 1, 1, EMPTY_RESET);
        send_item(OP_PARENT, 1, 1, 40);
        send_item(OP_LCHILD, 1, 1, 10);
        send_item(OP_RCHILD, 1, 1, 10);
        send_item(OP_LSIB, 1, 1, 30);
        send_item(OP_RCHILD, 1, 1, 40);
        send_item(OP_PARENT, 1, 1, EMPTY_RESET);
        send_item(OP_LCHILD, 1, 1, 99);
        send_item(OP_READ, 0, 1, 0);
        send_item(OP_WRITE, 2, 3, 7);
        for (int lvl = 4; lvl <= 7; lvl++)
            send_item(OP_WRITE, LAYER_W'(lvl), 1, VAL_W'(10 * lvl + 10));
        send_item(OP_RSIB, 1, 1, 80);
        send_item(OP_LCHILD, 1, 1, 80);
        send_item(OP_WRITE, 3, 2, 255);
        send_item(OP_READ, 7, 127, 255);
        send_item(OP_WRITE, 7, 1, EMPTY_RESET);
        send_item(OP_CLEAR, 1, 1, 0);

        // The first phase keeps the old store, so nodes holding the former empty code count
        // as filled under the new one.
        for (int ph = 0; ph < 5; ph++)
        begin
            write_blank(phase_codes[ph]);
            foreach (key_pool[i])
                key_pool[i] = VAL_W'($urandom_range(0, 255));
            if (ph != 0)
                send_item(OP_CLEAR, 1, 1, 0);
            if (ph == 2)
            begin
                run_mix(100);
                sink_hold = 1'b1;
                run_mix(200);
            end
            else if (ph == 4)
            begin
                run_mix(150);
                calm = 1'b1;
                run_mix(150);
            end
            else
                run_mix(300);
        end

        drain();
        repeat (200) @(negedge clk);
        $display("Checked %0d results from %0d operations over five empty codes,",
                 replies_checked, items_sent);
        $display("with %0d clears, %0d writes, %0d reads, %0d key lookups and a long output stall.",
                 op_tally[OP_CLEAR], op_tally[OP_WRITE], op_tally[OP_READ],
                 items_sent - op_tally[OP_CLEAR] - op_tally[OP_WRITE] - op_tally[OP_READ]);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
